>>> rtl/pgsc_pkg.sv
package pgsc_pkg;

  localparam int POS_W  = 24;
  localparam int SPD_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ROOT_W = DIFF_W;
  localparam int ACC_W  = SQ_W + 1;
  localparam int DAMP_W = SPD_W + 2;
  localparam int GAP_W  = 23;
  localparam int GAIN_W = 16;
  localparam int OUT_W  = 17;

  typedef enum logic [2:0] {
    REG_TARGET_GAP  = 3'd0,
    REG_TICK_LENGTH = 3'd1,
    REG_GAIN_CORR   = 3'd2,
    REG_GAIN_DAMP   = 3'd3,
    REG_OVER_MARGIN = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [SPD_W-1:0] own_speed;
    logic signed [POS_W-1:0] front_x;
    logic signed [POS_W-1:0] front_y;
    logic        [SPD_W-1:0] lead_speed;
    logic        [SPD_W-1:0] base_speed;
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] cmd_speed;
    logic             clamped_low;
    logic             clamped_high;
  } out_item_t;

  // values that ride alongside the root through the chain
  typedef struct packed {
    logic signed [DAMP_W-1:0] damp;
    logic        [SPD_W-1:0]  proj;
    logic        [SPD_W-1:0]  base;
  } side_t;

endpackage

>>> rtl/pgsc_cell.sv
module pgsc_cell #(
  parameter int K = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  input  logic [pgsc_pkg::SQ_W-1:0]  n_i,
  input  logic [pgsc_pkg::ACC_W-1:0] r_i,
  input  pgsc_pkg::side_t        side_i,
  output logic                   vld_o,
  output logic [pgsc_pkg::SQ_W-1:0]  n_o,
  output logic [pgsc_pkg::ACC_W-1:0] r_o,
  output pgsc_pkg::side_t        side_o
);
  import pgsc_pkg::*;

  localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * K);

  logic             vld_r;
  logic [SQ_W-1:0]  n_r, n_nxt;
  logic [ACC_W-1:0] r_r, r_nxt, trial;
  side_t            side_r;

  // one restoring step of the square root
  always_comb begin
    trial = r_i + BIT;
    if ({1'b0, n_i} >= trial) begin
      n_nxt = n_i - trial[SQ_W-1:0];
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    r_r    <= r_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign r_o    = r_r;
  assign side_o = side_r;

endmodule

>>> rtl/platoon_gap_speed_controller_core.sv
// Follower speed controller. One item is taken in every clock cycle (busy is
// always low). Its result is shown on out_data with out_strobe after passing
// through registered stages for the difference, squaring and summing, a row
// of 25 square-root cells that each settle one bit of the gap, and stages for
// the error, the correction product and the clamp. The receiver cannot stall,
// so each strobe must be taken in the cycle it is shown. Registers must be
// written over the APB port only while no item is in flight; the block itself
// does not enforce this.
module platoon_gap_speed_controller_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pgsc_pkg::in_item_t   in_data,
  output logic                 out_strobe,
  output pgsc_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pgsc_pkg::*;

  localparam int NCELL = ROOT_W;
  localparam int LAT   = NCELL + 6;

  // configuration registers
  logic [GAP_W-1:0]  tgap_r;
  logic [GAIN_W-1:0] tick_r, gcorr_r, gdamp_r;
  logic [SPD_W-1:0]  margin_r;
  logic              wr_en;
  reg_idx_t          widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgap_r   <= GAP_W'(2560);
      tick_r   <= GAIN_W'(6554);
      gcorr_r  <= GAIN_W'(22938);
      gdamp_r  <= GAIN_W'(45875);
      margin_r <= SPD_W'(6400);
    end else if (wr_en) begin
      case (widx)
        REG_TARGET_GAP:  tgap_r   <= pwdata[GAP_W-1:0];
        REG_TICK_LENGTH: tick_r   <= pwdata[GAIN_W-1:0];
        REG_GAIN_CORR:   gcorr_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN_DAMP:   gdamp_r  <= pwdata[GAIN_W-1:0];
        REG_OVER_MARGIN: margin_r <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (widx)
      REG_TARGET_GAP:  prdata = {9'd0, tgap_r};
      REG_TICK_LENGTH: prdata = {16'd0, tick_r};
      REG_GAIN_CORR:   prdata = {16'd0, gcorr_r};
      REG_GAIN_DAMP:   prdata = {16'd0, gdamp_r};
      REG_OVER_MARGIN: prdata = {16'd0, margin_r};
      default:         prdata = 32'd0;
    endcase
  end

  // stage 1: position differences and speed products
  logic                          v1_r;
  logic signed [DIFF_W-1:0]      dx_r, dy_r;
  logic signed [SPD_W+GAIN_W+1:0] dprod_r;
  logic [SPD_W+GAIN_W-1:0]       pprod_r;
  logic [SPD_W-1:0]              base1_r;
  logic signed [SPD_W:0]         sdiff;

  assign sdiff = $signed({1'b0, in_data.lead_speed}) - $signed({1'b0, in_data.own_speed});

  always_ff @(posedge clk) begin
    dx_r    <= {in_data.own_x[POS_W-1], in_data.own_x}
             - {in_data.front_x[POS_W-1], in_data.front_x};
    dy_r    <= {in_data.own_y[POS_W-1], in_data.own_y}
             - {in_data.front_y[POS_W-1], in_data.front_y};
    dprod_r <= sdiff * $signed({1'b0, gdamp_r});
    pprod_r <= in_data.lead_speed * tick_r;
    base1_r <= in_data.base_speed;
  end

  // stage 2: squares of the magnitudes, floor shifts of the speed terms
  logic                v2_r;
  logic [SQ_W-1:0]     sqx_r, sqy_r;
  side_t               side2_r;
  logic [DIFF_W-1:0]   ax, ay;

  assign ax = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign ay = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);

  always_ff @(posedge clk) begin
    sqx_r        <= ax * ax;
    sqy_r        <= ay * ay;
    side2_r.damp <= dprod_r[SPD_W+GAIN_W+1:GAIN_W];
    side2_r.proj <= pprod_r[SPD_W+GAIN_W-1:GAIN_W];
    side2_r.base <= base1_r;
  end

  // stage 3: sum of squares feeds the root chain
  logic            v3_r;
  logic [SQ_W-1:0] sum_r;
  side_t           side3_r;

  always_ff @(posedge clk) begin
    sum_r   <= sqx_r + sqy_r;
    side3_r <= side2_r;
  end

  // root chain: cell i settles result bit NCELL-1-i
  logic             cv [NCELL+1];
  logic [SQ_W-1:0]  cn [NCELL+1];
  logic [ACC_W-1:0] cr [NCELL+1];
  side_t            cs [NCELL+1];

  assign cv[0] = v3_r;
  assign cn[0] = sum_r;
  assign cr[0] = '0;
  assign cs[0] = side3_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pgsc_cell #(.K(NCELL - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (cv[i]),
      .n_i    (cn[i]),
      .r_i    (cr[i]),
      .side_i (cs[i]),
      .vld_o  (cv[i+1]),
      .n_o    (cn[i+1]),
      .r_o    (cr[i+1]),
      .side_o (cs[i+1])
    );
  end

  // stage 4: projected gap error
  localparam int ERR_W = ROOT_W + 2;
  logic                    v4_r;
  logic signed [ERR_W-1:0] err_r;
  side_t                   side4_r;

  always_ff @(posedge clk) begin
    err_r   <= $signed({2'b0, cr[NCELL][ROOT_W-1:0]})
             - $signed({{(ERR_W-GAP_W){1'b0}}, tgap_r})
             - $signed({{(ERR_W-SPD_W){1'b0}}, cs[NCELL].proj});
    side4_r <= cs[NCELL];
  end

  // stage 5: correction product
  localparam int CP_W = ERR_W + GAIN_W + 1;
  logic                   v5_r;
  logic signed [CP_W-1:0] cprod_r;
  side_t                  side5_r;

  always_ff @(posedge clk) begin
    cprod_r <= err_r * $signed({1'b0, gcorr_r});
    side5_r <= side4_r;
  end

  // stage 6: sum and clamp
  localparam int RAW_W = CP_W - GAIN_W + 1;
  logic signed [RAW_W-1:0] raw, lim;
  out_item_t               res_nxt, res_r;
  logic                    v6_r;

  always_comb begin
    raw = $signed({{(RAW_W-SPD_W){1'b0}}, side5_r.base})
        + RAW_W'(side5_r.damp)
        + RAW_W'($signed(cprod_r[CP_W-1:GAIN_W]));
    lim = $signed({{(RAW_W-SPD_W){1'b0}}, side5_r.base})
        + $signed({{(RAW_W-SPD_W){1'b0}}, margin_r});
    res_nxt = '0;
    if (raw < 0) begin
      res_nxt.clamped_low = 1'b1;
    end else if (raw > lim) begin
      res_nxt.cmd_speed    = lim[OUT_W-1:0];
      res_nxt.clamped_high = 1'b1;
    end else begin
      res_nxt.cmd_speed = raw[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // valid chain outside the cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= cv[NCELL];
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign out_strobe = v6_r;
  assign out_data   = res_r;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result without matching transfer");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.clamped_low && out_data.clamped_high))
    else $error("both clamp flags set");

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.clamped_low) |-> (out_data.cmd_speed == '0))
    else $error("low clamp with non-zero speed");

endmodule

>>> tb/platoon_gap_speed_controller_core_test.sv
`timescale 1ns / 1ps

module platoon_gap_speed_controller_core_test;
  import pgsc_pkg::*;

  localparam int PIPE_DEPTH  = 31;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 6;
  localparam int PER_PHASE   = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_strobe;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  platoon_gap_speed_controller_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // controller settings as the block should hold them
  logic [22:0] gap_setpoint;
  logic [15:0] tick_q16;
  logic [15:0] kp_q16;
  logic [15:0] kd_q16;
  logic [15:0] margin;

  out_item_t speed_queue[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        low_clamps = 0;
  int        high_clamps = 0;
  int        cycles = 0;
  logic      busy_seen = 1'b0;

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic out_item_t follow_speed(in_item_t it);
    longint    dx, dy, gap, proj, err, damp, corr, raw, lim;
    out_item_t res;
    dx = longint'(it.own_x) - longint'(it.front_x);
    dy = longint'(it.own_y) - longint'(it.front_y);
    gap = longint'(root_floor(dx * dx + dy * dy));
    proj = (longint'(it.lead_speed) * longint'(tick_q16)) >>> 16;
    err = gap - longint'(gap_setpoint) - proj;
    damp = ((longint'(it.lead_speed) - longint'(it.own_speed)) * longint'(kd_q16)) >>> 16;
    corr = (err * longint'(kp_q16)) >>> 16;
    raw = longint'(it.base_speed) + damp + corr;
    lim = longint'(it.base_speed) + longint'(margin);
    res = '0;
    if (raw < 0) begin
      res.clamped_low = 1'b1;
    end else if (raw > lim) begin
      res.cmd_speed = lim[OUT_W-1:0];
      res.clamped_high = 1'b1;
    end else begin
      res.cmd_speed = raw[OUT_W-1:0];
    end
    if (!res.clamped_low && (res.clamped_high ? lim : raw) > 131071) begin
      res.cmd_speed = '1;
      res.clamped_high = 1'b1;
    end
    return res;
  endfunction

  // busy only moves at the rising edge, so the falling-edge copy is stable
  always @(negedge clk) busy_seen <= busy;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL platoon_gap_speed_controller_core");
      $finish;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      results_seen <= results_seen + 1;
      if (out_data.clamped_low) low_clamps <= low_clamps + 1;
      if (out_data.clamped_high) high_clamps <= high_clamps + 1;
      if (speed_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data);
      end else begin
        want = speed_queue.pop_front();
        if (out_data !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: speed %0d/%0d low %b/%b high %b/%b (exp/got)",
                     want.cmd_speed, out_data.cmd_speed, want.clamped_low,
                     out_data.clamped_low, want.clamped_high, out_data.clamped_high);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET_GAP:  gap_setpoint = value[22:0];
      REG_TICK_LENGTH: tick_q16 = value[15:0];
      REG_GAIN_CORR:   kp_q16 = value[15:0];
      REG_GAIN_DAMP:   kd_q16 = value[15:0];
      REG_OVER_MARGIN: margin = value[15:0];
      default: ;
    endcase
    // bus left idle between transfers
    @(posedge clk);
  endtask

  // hold until the pipeline has drained
  task automatic drain();
    while (speed_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // one input transfer after a random gap; expectation is pushed on acceptance
  task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
    int idle;
    idle = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy_seen);
    speed_queue.push_back(fixed ? fixed_res : follow_speed(it));
    items_sent++;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    logic [159:0] noise;
    logic [23:0] dx, dy;
    int span;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    // mostly vehicles near each other so the gap sits around the set point
    if ($urandom_range(0, 9) < 7) begin
      span = 1 << $urandom_range(4, 16);
      dx = 24'($urandom_range(0, 2 * span) - span);
      dy = 24'($urandom_range(0, 2 * span) - span);
      it.front_x = it.own_x + dx;
      it.front_y = it.own_y + dy;
    end
    return it;
  endfunction

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t res;
  } drive_row_t;

  drive_row_t drive_rows[$];

  initial begin
    in_item_t  it;
    drive_row_t row;
    gap_setpoint = 23'd2560;
    tick_q16 = 16'd6554;
    kp_q16 = 16'd22938;
    kd_q16 = 16'd45875;
    margin = 16'd6400;

    // directed rows: still vehicles on top of each other, extreme gaps, speeds
    row.stim = '0; row.fixed = 1; row.res = '{cmd_speed: 0, clamped_low: 1, clamped_high: 0};
    drive_rows.push_back(row);
    row.stim = '0;
    row.stim.own_x = 24'h7fffff; row.stim.front_x = 24'h800000; row.stim.base_speed = 16'd1000;
    row.res = '{cmd_speed: 7400, clamped_low: 0, clamped_high: 1};
    drive_rows.push_back(row);
    row.fixed = 0;
    row.stim = '1; drive_rows.push_back(row);
    row.stim = '0; row.stim.own_x = 24'h800000; row.stim.own_y = 24'h800000;
    row.stim.front_x = 24'h7fffff; row.stim.front_y = 24'h7fffff;
    row.stim.base_speed = 16'hffff; drive_rows.push_back(row);
    row.stim = '0; row.stim.own_x = 24'd2560; row.stim.base_speed = 16'd5000;
    drive_rows.push_back(row);
    row.stim.lead_speed = 16'hffff; drive_rows.push_back(row);
    row.stim.lead_speed = 16'd0; row.stim.own_speed = 16'hffff; drive_rows.push_back(row);
    row.stim.own_speed = 16'd4000; row.stim.lead_speed = 16'd4000;
    row.stim.own_y = 24'h800000; row.stim.front_y = 24'h800000; drive_rows.push_back(row);
    row.stim.own_x = 24'hffffff; row.stim.front_x = 24'd1; drive_rows.push_back(row);
    row.stim.base_speed = 16'hffff; row.stim.own_x = 24'd3000; drive_rows.push_back(row);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drive_rows[i]) send_item(drive_rows[i].stim, drive_rows[i].fixed, drive_rows[i].res);
    start <= 1'b0;
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: ; // reset values
        1: begin
          write_reg(REG_TARGET_GAP, 32'h7fffff); write_reg(REG_TICK_LENGTH, 32'hffff);
          write_reg(REG_GAIN_CORR, 32'hffff); write_reg(REG_GAIN_DAMP, 32'hffff);
          write_reg(REG_OVER_MARGIN, 32'hffff);
        end
        2: begin
          write_reg(REG_TARGET_GAP, 32'h0); write_reg(REG_TICK_LENGTH, 32'h0);
          write_reg(REG_GAIN_CORR, 32'h0); write_reg(REG_GAIN_DAMP, 32'h0);
          write_reg(REG_OVER_MARGIN, 32'h0);
        end
        3: begin
          write_reg(REG_TARGET_GAP, 32'h0); write_reg(REG_GAIN_CORR, 32'hffff);
          write_reg(REG_GAIN_DAMP, 32'hffff); write_reg(REG_OVER_MARGIN, 32'hffff);
        end
        default: begin
          write_reg(REG_TARGET_GAP, $urandom_range(0, 8000));
          write_reg(REG_TICK_LENGTH, $urandom);
          write_reg(REG_GAIN_CORR, $urandom);
          write_reg(REG_GAIN_DAMP, $urandom);
          write_reg(REG_OVER_MARGIN, $urandom);
        end
      endcase
      for (int k = 0; k < PER_PHASE; k++) begin
        // stop feeding mid-phase until everything in flight has come back
        if (k == PER_PHASE / 2) begin
          start <= 1'b0;
          while (speed_queue.size() != 0) @(posedge clk);
        end
        it = random_item();
        send_item(it, 0, '0);
      end
      start <= 1'b0;
      drain();
    end

    $display("%0d items sent, %0d results checked (%0d low clamps, %0d high clamps)",
             items_sent, results_seen, low_clamps, high_clamps);
    $display("settings covered: reset, all maxima, all zero and random, %0d mismatches",
             mismatches);
    if (mismatches == 0 && speed_queue.size() == 0) begin
      $display("PASS platoon_gap_speed_controller_core");
    end else begin
      $display("FAIL platoon_gap_speed_controller_core");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pgsc_pkg.sv
rtl/pgsc_cell.sv
rtl/platoon_gap_speed_controller_core.sv
tb/platoon_gap_speed_controller_core_test.sv
